// ----- hw/rtl/tsq_pkg.sv -----
// ----------------------------------------------------------------------------
// Tetrahedron shape quality - shared package
// Widths, register map, sideband type and edge vertex tables.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QFRAC_BITS_DEF = 24;
    localparam int QOUT_BITS      = 20;
    localparam int THR_BITS       = 16;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;

    // limb width of the split wide products
    localparam int MUL_LIMB       = 24;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);

    // register indexes
    localparam logic REG_VOL_THR = 1'b0;
    localparam logic REG_LEN_THR = 1'b1;

    // sideband that travels with each beat
    typedef struct packed {
        logic vld;
        logic degen;
    } t_tag;

    // edge s runs from vertex seg_from(s) to vertex seg_to(s); 0..2 are ab, ac, ad
    function automatic logic [1:0] seg_from(input int s);
        logic [1:0] v;
        case (s)
            0, 1, 2: v = 2'd0;
            3, 4:    v = 2'd1;
            default: v = 2'd2;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] seg_to(input int s);
        logic [1:0] v;
        case (s)
            0:       v = 2'd1;
            1, 3:    v = 2'd2;
            default: v = 2'd3;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/tsq_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit in QB bits.
// ----------------------------------------------------------------------------
module tsq_div #(
    parameter int XW = 148,
    parameter int YW = 114,
    parameter int QB = 40
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsq_pkg::t_tag  i_tag,
    input  logic [XW-1:0]  i_num,
    input  logic [YW-1:0]  i_den,
    output tsq_pkg::t_tag  o_tag,
    output logic [QB-1:0]  o_quo,
    output logic           o_sat
);

    localparam int CW = ((XW > YW + QB) ? XW : (YW + QB)) + 1;

    tsq_pkg::t_tag r_tag [QB+1];
    logic [CW-1:0] r_rem [QB+1];
    logic [YW-1:0] r_den [QB+1];
    logic [QB-1:0] r_quo [QB+1];
    logic          r_sat [QB+1];

    // stage 0: capture and overflow check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= i_tag;
        end
        r_rem[0] <= CW'(i_num);
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_sat[0] <= CW'(i_num) >= (CW'(i_den) << QB);
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        localparam int B = QB - k;
        logic [CW-1:0] w_trial;
        logic          w_ge;
        logic [QB-1:0] w_quo;

        assign w_trial = CW'(r_den[k-1]) << B;
        assign w_ge    = r_rem[k-1] >= w_trial;

        always_comb begin
            w_quo    = r_quo[k-1];
            w_quo[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else begin
                r_tag[k] <= r_tag[k-1];
            end
            r_rem[k] <= w_ge ? (r_rem[k-1] - w_trial) : r_rem[k-1];
            r_den[k] <= r_den[k-1];
            r_quo[k] <= w_quo;
            r_sat[k] <= r_sat[k-1];
        end
    end

    assign o_tag = r_tag[QB];
    assign o_quo = r_quo[QB];
    assign o_sat = r_sat[QB];

endmodule

// ----- hw/rtl/tsq_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage; saturated input gives an all-ones root.
// ----------------------------------------------------------------------------
module tsq_sqrt #(
    parameter int QW = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsq_pkg::t_tag   i_tag,
    input  logic [2*QW-1:0] i_num,
    input  logic            i_sat,
    output tsq_pkg::t_tag   o_tag,
    output logic [QW-1:0]   o_root
);

    localparam int NW = 2 * QW;
    localparam int RW = NW + 2;

    tsq_pkg::t_tag r_tag  [1:QW];
    logic [RW-1:0] r_rem  [1:QW];
    logic [QW-1:0] r_root [1:QW];
    logic          r_sat  [1:QW];

    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int B = QW - k;
        tsq_pkg::t_tag w_tag;
        logic [RW-1:0] w_rem;
        logic [QW-1:0] w_root;
        logic          w_sat;
        logic [RW-1:0] w_trial;
        logic          w_ge;
        logic [QW-1:0] w_next;

        if (k == 1) begin : g_first
            assign w_tag  = i_tag;
            assign w_rem  = RW'(i_num);
            assign w_root = '0;
            assign w_sat  = i_sat;
        end else begin : g_rest
            assign w_tag  = r_tag[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_sat  = r_sat[k-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign w_trial = (RW'(w_root) << (B + 1)) + (RW'(1) << (2 * B));
        assign w_ge    = w_rem >= w_trial;

        always_comb begin
            w_next    = w_root;
            w_next[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else begin
                r_tag[k] <= w_tag;
            end
            r_rem[k]  <= w_ge ? (w_rem - w_trial) : w_rem;
            r_root[k] <= w_next;
            r_sat[k]  <= w_sat;
        end
    end

    assign o_tag  = r_tag[QW];
    assign o_root = r_sat[QW] ? '1 : r_root[QW];

endmodule

// ----- hw/rtl/tetrahedron_shape_quality_unit.sv -----
// ----------------------------------------------------------------------------
// Tetrahedron shape quality unit
// Streams tetrahedra; gives 6*volume / (sum of squared edges)^1.5 in Q0.F.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the twelve vertex coordinates with start high; a beat is
//   taken at every edge where start is high and busy is low. busy never
//   rises, so one tetrahedron can enter every cycle.
//   Output: o_done pulses for one cycle with o_quality and o_degenerate.
//   The receiver cannot stall the block; each result shows for one cycle.
//   Pipeline: nine arithmetic stages (edges; cross products and edge
//   lengths; triple product and length sum; limb products, row sums and
//   totals for the squares of volume and length sum; the same three for the
//   cube of the length sum), a divider with one quotient bit per stage, a
//   square root with one root bit per stage and the output register.
//   Throughput is one beat a cycle.
//   Configuration: APB, volume threshold at 0x0, length threshold at 0x4.
//   Write thresholds only while no beat is in flight.
//   Reset (synchronous, active low) empties the pipeline and sets both
//   thresholds to 1.
// ----------------------------------------------------------------------------
module tetrahedron_shape_quality_unit #(
    parameter int COORD_BITS        = tsq_pkg::COORD_BITS_DEF,
    parameter int QUALITY_FRAC_BITS = tsq_pkg::QFRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsq_pkg::APB_AW-1:0]     paddr,
    input  logic [tsq_pkg::APB_DW-1:0]     pwdata,
    output logic [tsq_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_BITS-1:0]   i_a_x,
    input  logic signed [COORD_BITS-1:0]   i_a_y,
    input  logic signed [COORD_BITS-1:0]   i_a_z,
    input  logic signed [COORD_BITS-1:0]   i_b_x,
    input  logic signed [COORD_BITS-1:0]   i_b_y,
    input  logic signed [COORD_BITS-1:0]   i_b_z,
    input  logic signed [COORD_BITS-1:0]   i_c_x,
    input  logic signed [COORD_BITS-1:0]   i_c_y,
    input  logic signed [COORD_BITS-1:0]   i_c_z,
    input  logic signed [COORD_BITS-1:0]   i_d_x,
    input  logic signed [COORD_BITS-1:0]   i_d_y,
    input  logic signed [COORD_BITS-1:0]   i_d_z,
    output logic                           o_done,
    output logic [tsq_pkg::QOUT_BITS-1:0]  o_quality,
    output logic                           o_degenerate
);

    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;
    localparam int VW   = 2 * D + 1;
    localparam int VOLW = 3 * D + 3;
    localparam int LENW = 2 * D + 2;
    localparam int RAPW = 2 * C + 6;
    localparam int QW   = tsq_pkg::QOUT_BITS;
    localparam int QB   = 2 * QW;
    localparam int XW   = 2 * VOLW + 2 * QUALITY_FRAC_BITS;
    localparam int YW   = 3 * RAPW;
    localparam int TW   = tsq_pkg::THR_BITS;
    localparam int LAT  = 9 + (QB + 1) + QW + 1;

    // limb split of the wide products
    localparam int LB   = tsq_pkg::MUL_LIMB;
    localparam int PW   = 2 * LB;
    localparam int VMW  = VOLW - 1;
    localparam int NV   = (VMW + LB - 1) / LB;
    localparam int NR   = (RAPW + LB - 1) / LB;
    localparam int R2W  = 2 * RAPW;
    localparam int NR2  = (R2W + LB - 1) / LB;
    localparam int VLW  = NV * LB;
    localparam int RLW  = NR * LB;
    localparam int C2W  = NR2 * LB;
    localparam int VRW  = (NV + 1) * LB;
    localparam int RRW  = (NR + 1) * LB;
    localparam int CRW  = (NR2 + 1) * LB;
    localparam int VSQW = 2 * VMW;

    // ---------------- configuration ----------------
    logic [TW-1:0] r_vthr;
    logic [TW-1:0] r_lthr;
    logic          w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vthr <= tsq_pkg::THR_RESET;
            r_lthr <= tsq_pkg::THR_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                tsq_pkg::REG_VOL_THR: r_vthr <= pwdata[TW-1:0];
                tsq_pkg::REG_LEN_THR: r_lthr <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tsq_pkg::REG_VOL_THR: prdata = tsq_pkg::APB_DW'(r_vthr);
            tsq_pkg::REG_LEN_THR: prdata = tsq_pkg::APB_DW'(r_lthr);
            default:              prdata = '0;
        endcase
    end

    // ---------------- stage 1: edge vectors ----------------
    logic signed [C-1:0] w_vtx [4][3];
    logic signed [D-1:0] n_s1_e [6][3];
    logic signed [D-1:0] r_s1_e [6][3];
    tsq_pkg::t_tag       r_s1_tag;

    assign w_vtx[0][0] = i_a_x;
    assign w_vtx[0][1] = i_a_y;
    assign w_vtx[0][2] = i_a_z;
    assign w_vtx[1][0] = i_b_x;
    assign w_vtx[1][1] = i_b_y;
    assign w_vtx[1][2] = i_b_z;
    assign w_vtx[2][0] = i_c_x;
    assign w_vtx[2][1] = i_c_y;
    assign w_vtx[2][2] = i_c_z;
    assign w_vtx[3][0] = i_d_x;
    assign w_vtx[3][1] = i_d_y;
    assign w_vtx[3][2] = i_d_z;

    always_comb begin
        for (int s = 0; s < 6; s++) begin
            for (int a = 0; a < 3; a++) begin
                n_s1_e[s][a] = D'(w_vtx[tsq_pkg::seg_to(s)][a])
                             - D'(w_vtx[tsq_pkg::seg_from(s)][a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else begin
            r_s1_tag <= '{vld: start && !busy, degen: 1'b0};
        end
        r_s1_e <= n_s1_e;
    end

    // ---------------- stage 2: cross product, squared edge lengths ----------------
    logic signed [2*D-1:0] w_p [6];
    logic signed [VW-1:0]  n_s2_v [3];
    logic signed [VW-1:0]  r_s2_v [3];
    logic signed [D-1:0]   r_s2_ab [3];
    logic [LENW-1:0]       n_s2_len [6];
    logic [LENW-1:0]       r_s2_len [6];
    tsq_pkg::t_tag         r_s2_tag;

    // ac = edge 1, ad = edge 2
    assign w_p[0] = r_s1_e[1][1] * r_s1_e[2][2];
    assign w_p[1] = r_s1_e[1][2] * r_s1_e[2][1];
    assign w_p[2] = r_s1_e[1][2] * r_s1_e[2][0];
    assign w_p[3] = r_s1_e[1][0] * r_s1_e[2][2];
    assign w_p[4] = r_s1_e[1][0] * r_s1_e[2][1];
    assign w_p[5] = r_s1_e[1][1] * r_s1_e[2][0];

    always_comb begin
        logic signed [2*D-1:0] sq;
        n_s2_v[0] = VW'(w_p[0]) - VW'(w_p[1]);
        n_s2_v[1] = VW'(w_p[2]) - VW'(w_p[3]);
        n_s2_v[2] = VW'(w_p[4]) - VW'(w_p[5]);
        for (int s = 0; s < 6; s++) begin
            n_s2_len[s] = '0;
            for (int a = 0; a < 3; a++) begin
                sq          = r_s1_e[s][a] * r_s1_e[s][a];
                n_s2_len[s] = n_s2_len[s] + LENW'($unsigned(sq));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag <= '0;
        end else begin
            r_s2_tag <= r_s1_tag;
        end
        r_s2_v   <= n_s2_v;
        r_s2_ab  <= r_s1_e[0];
        r_s2_len <= n_s2_len;
    end

    // ---------------- stage 3: triple product, length sum ----------------
    logic signed [D+VW-1:0] w_t [3];
    logic [RAPW-1:0]        n_s3_rap;
    logic signed [VOLW-1:0] r_s3_vol;
    logic [RAPW-1:0]        r_s3_rap;
    tsq_pkg::t_tag          r_s3_tag;

    for (genvar k = 0; k < 3; k++) begin : g_dot
        assign w_t[k] = r_s2_ab[k] * r_s2_v[k];
    end

    always_comb begin
        n_s3_rap = '0;
        for (int s = 0; s < 6; s++) begin
            n_s3_rap = n_s3_rap + RAPW'(r_s2_len[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_tag <= '0;
        end else begin
            r_s3_tag <= r_s2_tag;
        end
        r_s3_vol <= VOLW'(w_t[0]) + VOLW'(w_t[1]) + VOLW'(w_t[2]);
        r_s3_rap <= n_s3_rap;
    end

    // ---------------- stage 4: thresholds, limb products of the squares ----------------
    logic              w_bad;
    logic [VLW-1:0]    w_vm;
    logic [RLW-1:0]    w_rm;
    logic [PW-1:0]     r_s4_vpp [NV][NV];
    logic [PW-1:0]     r_s4_rpp [NR][NR];
    logic [RAPW-1:0]   r_s4_rap;
    tsq_pkg::t_tag     r_s4_tag;

    // negative or small volume, short edges, or all vertices equal
    assign w_bad = r_s3_vol[VOLW-1]
                || ($unsigned(r_s3_vol) < VOLW'(r_vthr))
                || (r_s3_rap < RAPW'(r_lthr))
                || (r_s3_rap == '0);

    // a negative volume is flagged, so only the magnitude bits matter
    assign w_vm = VLW'(r_s3_vol[VMW-1:0]);
    assign w_rm = RLW'(r_s3_rap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_tag <= '0;
        end else begin
            r_s4_tag <= '{vld: r_s3_tag.vld, degen: w_bad};
        end
        for (int i = 0; i < NV; i++) begin
            for (int j = 0; j < NV; j++) begin
                r_s4_vpp[i][j] <= w_vm[i*LB +: LB] * w_vm[j*LB +: LB];
            end
        end
        for (int i = 0; i < NR; i++) begin
            for (int j = 0; j < NR; j++) begin
                r_s4_rpp[i][j] <= w_rm[i*LB +: LB] * w_rm[j*LB +: LB];
            end
        end
        r_s4_rap <= r_s3_rap;
    end

    // ---------------- stage 5: row sums of the squares ----------------
    logic [VRW-1:0]  n_s5_vrow [NV];
    logic [VRW-1:0]  r_s5_vrow [NV];
    logic [RRW-1:0]  n_s5_rrow [NR];
    logic [RRW-1:0]  r_s5_rrow [NR];
    logic [RAPW-1:0] r_s5_rap;
    tsq_pkg::t_tag   r_s5_tag;

    always_comb begin
        for (int i = 0; i < NV; i++) begin
            n_s5_vrow[i] = '0;
            for (int j = 0; j < NV; j++) begin
                n_s5_vrow[i] = n_s5_vrow[i] + (VRW'(r_s4_vpp[i][j]) << (LB * j));
            end
        end
        for (int i = 0; i < NR; i++) begin
            n_s5_rrow[i] = '0;
            for (int j = 0; j < NR; j++) begin
                n_s5_rrow[i] = n_s5_rrow[i] + (RRW'(r_s4_rpp[i][j]) << (LB * j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_tag <= '0;
        end else begin
            r_s5_tag <= r_s4_tag;
        end
        r_s5_vrow <= n_s5_vrow;
        r_s5_rrow <= n_s5_rrow;
        r_s5_rap  <= r_s4_rap;
    end

    // ---------------- stage 6: squares of volume and length sum ----------------
    logic [VSQW-1:0] n_s6_vsq;
    logic [VSQW-1:0] r_s6_vsq;
    logic [R2W-1:0]  n_s6_rap2;
    logic [R2W-1:0]  r_s6_rap2;
    logic [RAPW-1:0] r_s6_rap;
    tsq_pkg::t_tag   r_s6_tag;

    always_comb begin
        n_s6_vsq = '0;
        for (int i = 0; i < NV; i++) begin
            n_s6_vsq = n_s6_vsq + (VSQW'(r_s5_vrow[i]) << (LB * i));
        end
        n_s6_rap2 = '0;
        for (int i = 0; i < NR; i++) begin
            n_s6_rap2 = n_s6_rap2 + (R2W'(r_s5_rrow[i]) << (LB * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_tag <= '0;
        end else begin
            r_s6_tag <= r_s5_tag;
        end
        r_s6_vsq  <= n_s6_vsq;
        r_s6_rap2 <= n_s6_rap2;
        r_s6_rap  <= r_s5_rap;
    end

    // ---------------- stage 7: limb products of the cube ----------------
    logic [C2W-1:0]  w_r2;
    logic [RLW-1:0]  w_r1;
    logic [PW-1:0]   r_s7_cpp [NR2][NR];
    logic [VSQW-1:0] r_s7_vsq;
    tsq_pkg::t_tag   r_s7_tag;

    assign w_r2 = C2W'(r_s6_rap2);
    assign w_r1 = RLW'(r_s6_rap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_tag <= '0;
        end else begin
            r_s7_tag <= r_s6_tag;
        end
        for (int i = 0; i < NR2; i++) begin
            for (int j = 0; j < NR; j++) begin
                r_s7_cpp[i][j] <= w_r2[i*LB +: LB] * w_r1[j*LB +: LB];
            end
        end
        r_s7_vsq <= r_s6_vsq;
    end

    // ---------------- stage 8: row sums of the cube ----------------
    logic [CRW-1:0]  n_s8_crow [NR];
    logic [CRW-1:0]  r_s8_crow [NR];
    logic [VSQW-1:0] r_s8_vsq;
    tsq_pkg::t_tag   r_s8_tag;

    always_comb begin
        for (int j = 0; j < NR; j++) begin
            n_s8_crow[j] = '0;
            for (int i = 0; i < NR2; i++) begin
                n_s8_crow[j] = n_s8_crow[j] + (CRW'(r_s7_cpp[i][j]) << (LB * i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_tag <= '0;
        end else begin
            r_s8_tag <= r_s7_tag;
        end
        r_s8_crow <= n_s8_crow;
        r_s8_vsq  <= r_s7_vsq;
    end

    // ---------------- stage 9: numerator and cube ----------------
    logic [YW-1:0] n_s9_den;
    logic [XW-1:0] r_s9_num;
    logic [YW-1:0] r_s9_den;
    tsq_pkg::t_tag r_s9_tag;

    always_comb begin
        n_s9_den = '0;
        for (int j = 0; j < NR; j++) begin
            n_s9_den = n_s9_den + (YW'(r_s8_crow[j]) << (LB * j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_tag <= '0;
        end else begin
            r_s9_tag <= r_s8_tag;
        end
        r_s9_num <= XW'(r_s8_vsq) << (2 * QUALITY_FRAC_BITS);
        r_s9_den <= n_s9_den;
    end

    // ---------------- divide, then square root ----------------
    tsq_pkg::t_tag w_div_tag;
    logic [QB-1:0] w_quo;
    logic          w_sat;
    tsq_pkg::t_tag w_sq_tag;
    logic [QW-1:0] w_root;

    tsq_div #(
        .XW (XW),
        .YW (YW),
        .QB (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s9_tag),
        .i_num   (r_s9_num),
        .i_den   (r_s9_den),
        .o_tag   (w_div_tag),
        .o_quo   (w_quo),
        .o_sat   (w_sat)
    );

    tsq_sqrt #(
        .QW (QW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_div_tag),
        .i_num   (w_quo),
        .i_sat   (w_sat),
        .o_tag   (w_sq_tag),
        .o_root  (w_root)
    );

    // ---------------- output register ----------------
    logic          r_done;
    logic [QW-1:0] r_quality;
    logic          r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_sq_tag.vld;
        end
        r_quality <= w_sq_tag.degen ? '0 : w_root;
        r_degen   <= w_sq_tag.degen;
    end

    assign o_done       = r_done;
    assign o_quality    = r_quality;
    assign o_degenerate = r_degen;

endmodule

// ----- hw/rtl/tsq_checker.sv -----
// ----------------------------------------------------------------------------
// Tetrahedron shape quality - port checker
// Watches the ports of the top level for result timing and flag rules.
// ----------------------------------------------------------------------------
module tsq_checker #(
    parameter int LAT = 71
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic [tsq_pkg::QOUT_BITS-1:0] o_quality,
    input logic                          o_degenerate
);

    // every accepted beat is followed by a result on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_done)
        else $error("result missing after accepted beat");

    // no result without a beat accepted earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_rst_n, LAT) |-> $past(start && !busy, LAT))
        else $error("result without accepted beat");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_degenerate |-> o_quality == '0)
        else $error("degenerate result with nonzero quality");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result straight after reset");

endmodule

bind tetrahedron_shape_quality_unit tsq_checker #(
    .LAT (LAT)
) u_tsq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_quality    (o_quality),
    .o_degenerate (o_degenerate)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Tetrahedron shape quality unit - testbench
// Streams tetrahedra through the unit under several threshold settings and
// checks each quality and degenerate flag against an exact integer predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int QOUT_BITS = tsq_pkg::QOUT_BITS;
    localparam int THR_BITS  = tsq_pkg::THR_BITS;
    localparam int APB_AW    = tsq_pkg::APB_AW;
    localparam int APB_DW    = tsq_pkg::APB_DW;
    localparam logic [THR_BITS-1:0] THR_RESET = tsq_pkg::THR_RESET;

    localparam int CB        = 16;
    localparam int QF        = 24;
    localparam int LAT       = 9 + (2*QOUT_BITS + 1) + QOUT_BITS + 1;
    localparam int CYC_LIMIT = 400000;
    localparam logic [APB_AW-1:0] ADDR_VOL = {tsq_pkg::REG_VOL_THR, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_LEN = {tsq_pkg::REG_LEN_THR, 2'b00};

    typedef logic signed [CB-1:0] t_tetra [12];

    class quality_scoreboard;
        logic [THR_BITS-1:0] vol_thr = THR_RESET;
        logic [THR_BITS-1:0] len_thr = THR_RESET;
        logic [QOUT_BITS-1:0] q_exp [$];
        logic                 d_exp [$];
        int mismatches = 0;
        int checked = 0;
        int flagged = 0;

        function void note_tetra(input t_tetra p);
            longint c [12];
            longint abx, aby, abz, acx, acy, acz, adx, ady, adz;
            longint bcx, bcy, bcz, bdx, bdy, bdz, cdx, cdy, cdz;
            longint vol, rap;
            logic [255:0] rhs, r3, w;
            logic [QOUT_BITS-1:0] q;
            logic [QOUT_BITS-1:0] cand;
            for (int i = 0; i < 12; i++) c[i] = longint'(p[i]);
            abx = c[3]-c[0]; aby = c[4]-c[1]; abz = c[5]-c[2];
            acx = c[6]-c[0]; acy = c[7]-c[1]; acz = c[8]-c[2];
            adx = c[9]-c[0]; ady = c[10]-c[1]; adz = c[11]-c[2];
            bcx = c[6]-c[3]; bcy = c[7]-c[4]; bcz = c[8]-c[5];
            bdx = c[9]-c[3]; bdy = c[10]-c[4]; bdz = c[11]-c[5];
            cdx = c[9]-c[6]; cdy = c[10]-c[7]; cdz = c[11]-c[8];
            vol = abx*(acy*adz - acz*ady) + aby*(acz*adx - acx*adz)
                + abz*(acx*ady - acy*adx);
            rap = abx*abx + aby*aby + abz*abz + acx*acx + acy*acy + acz*acz
                + adx*adx + ady*ady + adz*adz + bcx*bcx + bcy*bcy + bcz*bcz
                + bdx*bdx + bdy*bdy + bdz*bdz + cdx*cdx + cdy*cdy + cdz*cdz;
            q = '0;
            if (vol < 0 || vol < longint'(vol_thr) || rap < longint'(len_thr) || rap == 0) begin
                q_exp.push_back('0);
                d_exp.push_back(1'b1);
                return;
            end
            w   = 256'(vol);
            rhs = (w * w) << (2*QF);
            r3  = 256'(rap) * 256'(rap) * 256'(rap);
            // bitwise search for the largest q with q^2 * rap^3 <= vol^2 * 2^2F
            for (int b = QOUT_BITS-1; b >= 0; b--) begin
                cand = q | (QOUT_BITS'(1) << b);
                if (256'(cand) * 256'(cand) * r3 <= rhs) q = cand;
            end
            q_exp.push_back(q);
            d_exp.push_back(1'b0);
        endfunction

        function void check_result(input logic [QOUT_BITS-1:0] q, input logic d);
            logic [QOUT_BITS-1:0] eq;
            logic ed;
            if (q_exp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: quality %0d degenerate %0b", q, d);
                return;
            end
            eq = q_exp.pop_front();
            ed = d_exp.pop_front();
            checked++;
            if (ed) flagged++;
            if (q !== eq || d !== ed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: exp quality %0d degen %0b, got quality %0d degen %0b",
                             checked, eq, ed, q, d);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready, start = 1'b0, busy;
    logic signed [CB-1:0] crd [12] = '{default: '0};
    logic o_done, o_degenerate;
    logic [QOUT_BITS-1:0] o_quality;

    quality_scoreboard sb = new();
    int cycles = 0;
    int accepted = 0;
    bit no_idle = 1'b0;

    always #4 i_clk = ~i_clk;

    tetrahedron_shape_quality_unit #(.COORD_BITS(CB), .QUALITY_FRAC_BITS(QF)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .i_a_x(crd[0]), .i_a_y(crd[1]), .i_a_z(crd[2]),
        .i_b_x(crd[3]), .i_b_y(crd[4]), .i_b_z(crd[5]),
        .i_c_x(crd[6]), .i_c_y(crd[7]), .i_c_z(crd[8]),
        .i_d_x(crd[9]), .i_d_y(crd[10]), .i_d_z(crd[11]),
        .o_done(o_done), .o_quality(o_quality), .o_degenerate(o_degenerate)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) sb.check_result(o_quality, o_degenerate);
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [THR_BITS-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
        pwdata <= APB_DW'($urandom) & {{(APB_DW-THR_BITS){1'b1}}, {THR_BITS{1'b0}}}
                  | APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_VOL) sb.vol_thr = val;
        else sb.len_thr = val;
        // read back: setup, then sample on the access edge
        @(posedge i_clk);
        psel <= 1'b1; paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[THR_BITS-1:0] !== val) begin
            sb.mismatches++;
            if (sb.mismatches <= 10)
                $display("register readback at %0d: exp %0d got %0d", addr, val, prdata);
        end
        psel <= 1'b0; penable <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [THR_BITS-1:0] v, input logic [THR_BITS-1:0] l);
        start <= 1'b0;
        while (sb.q_exp.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
        apb_write(ADDR_VOL, v);
        apb_write(ADDR_LEN, l);
    endtask

    task automatic send_tetra(input t_tetra p);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int i = 0; i < 12; i++) crd[i] <= p[i];
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_tetra(p);
        accepted++;
    endtask

    function automatic t_tetra pack(input int ax, ay, az, bx, by, bz,
                                   input int cx, cy, cz, dx, dy, dz);
        t_tetra p;
        p = '{CB'(ax), CB'(ay), CB'(az), CB'(bx), CB'(by), CB'(bz),
              CB'(cx), CB'(cy), CB'(cz), CB'(dx), CB'(dy), CB'(dz)};
        return p;
    endfunction

    function automatic int clampc(input int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    function automatic t_tetra rand_tetra();
        t_tetra p;
        int base [3];
        int r, s, m;
        m = $urandom_range(0, 9);
        if (m < 3) begin
            for (int i = 0; i < 12; i++) p[i] = CB'($urandom);
        end else if (m < 6) begin
            // clustered vertices, spread anywhere from tiny to wide
            case ($urandom_range(0, 3))
                0: r = 3;
                1: r = 60;
                2: r = 2000;
                default: r = 16000;
            endcase
            for (int k = 0; k < 3; k++) base[k] = $urandom_range(0, 60000) - 30000;
            for (int i = 0; i < 12; i++)
                p[i] = CB'(clampc(base[i%3] + $urandom_range(0, 2*r) - r));
        end else begin
            // jittered regular tetrahedron, sometimes mirrored
            s = $urandom_range(1, 8000);
            r = $urandom_range(0, s/2);
            for (int k = 0; k < 3; k++) base[k] = $urandom_range(0, 20000) - 10000;
            p = pack(s, s, s, s, -s, -s, -s, -s, s, -s, s, -s);
            if ($urandom_range(0, 3) == 0) p = pack(s, s, s, s, -s, -s, -s, s, -s, -s, -s, s);
            for (int i = 0; i < 12; i++)
                p[i] = CB'(clampc(int'(p[i]) + base[i%3] + $urandom_range(0, 2*r) - r));
        end
        return p;
    endfunction

    task automatic directed_set();
        send_tetra(pack(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tetra(pack(5, -7, 9, 5, -7, 9, 5, -7, 9, 5, -7, 9));
        send_tetra(pack(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_tetra(pack(0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 0));
        send_tetra(pack(1, 1, 1, 1, -1, -1, -1, -1, 1, -1, 1, -1));
        send_tetra(pack(16383, 16383, 16383, 16383, -16383, -16383,
                        -16383, -16383, 16383, -16383, 16383, -16383));
        send_tetra(pack(-32768, -32768, -32768, 32767, -32768, -32768,
                        -32768, 32767, -32768, -32768, -32768, 32767));
        send_tetra(pack(-32768, -32768, -32768, 32767, -32768, -32768,
                        -32768, -32768, 32767, -32768, 32767, -32768));
        send_tetra(pack(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, -32768, 0));
        send_tetra(pack(32767, 32767, 32767, -32768, -32768, -32768,
                        32767, -32768, 32767, -32768, 32767, -32768));
        send_tetra(pack(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 1));
        send_tetra(pack(0, 0, 0, 2, 0, 0, 0, 2, 0, 0, 0, 2));
    endtask

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++) send_tetra(rand_tetra());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds first, then zero thresholds for flat and empty shapes
        directed_set();
        random_run(100);
        set_thresholds('0, '0);
        directed_set();
        random_run(180);
        set_thresholds('1, '1);
        random_run(160);
        set_thresholds(THR_BITS'($urandom), THR_BITS'($urandom_range(0, 400)));
        random_run(160);
        set_thresholds(THR_BITS'($urandom_range(0, 50)), THR_BITS'($urandom));
        random_run(160);
        no_idle = 1'b1;
        set_thresholds(THR_RESET, THR_RESET);
        random_run(160);

        start <= 1'b0;
        while (sb.q_exp.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);

        $display("%0d tetrahedra over six threshold settings, %0d results checked, %0d flagged",
                 accepted, sb.checked, sb.flagged);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- tetrahedron_shape_quality_unit.f -----
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_div.sv
hw/rtl/tsq_sqrt.sv
hw/rtl/tetrahedron_shape_quality_unit.sv
hw/rtl/tsq_checker.sv
tb/tb.sv
